// ===== design/assert_macros.svh =====
// Assertion macros used by the encoder top level.
// Both macros expect clk in scope; AR_ASSERT also expects rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define AR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
// Checked at every edge, reset included.
`define AR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define AR_ASSERT(lbl, prop)
`define AR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== design/are_pkg.sv =====
`timescale 1ns / 1ps

package are_pkg;

  localparam int SYM_W       = 9;
  localparam int TOT_W       = 17;
  localparam int PROD_W      = TOT_W + 32;
  localparam int INNER_W     = $clog2(PROD_W);
  localparam int RES_W       = 4;
  localparam int MAX_RESULTS = 12;
  localparam int PFX_ITERS   = 8;
  localparam int CUT_ITERS   = 16;
  localparam int FLUSH_BYTES = 4;

  localparam logic [31:0]      RANGE_MIN   = 32'h0000_ffff;
  localparam logic [31:0]      RANGE_FULL  = 32'hffff_ffff;
  localparam logic [31:0]      TOP_MASK    = 32'hff00_0000;
  localparam logic [23:0]      LOW_ZERO    = 24'h00_0000;
  localparam logic [TOT_W-1:0] TOTAL_LIMIT = 17'h0_ffff;
  localparam logic [4:0]       SHIFT_MAX   = 5'd31;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_MODEL_RST,
    OP_CLR,
    OP_START,
    OP_WALK,
    OP_MUL_A,
    OP_MUL_B,
    OP_DIV_LOAD_A,
    OP_DIV_LOAD_B,
    OP_DIV_STEP,
    OP_APPLY,
    OP_EMIT_SHIFT,
    OP_CUT,
    OP_INC,
    OP_SHIFT,
    OP_SUM,
    OP_SET_TOTAL,
    OP_FIN
  } op_t;

  typedef enum logic [4:0] {
    ST_CLR_INIT,
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_WALK_WAIT,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_A_LOAD,
    ST_DIV_A,
    ST_DIV_B_LOAD,
    ST_DIV_B,
    ST_APPLY,
    ST_PFX,
    ST_RANGE,
    ST_ADAPT,
    ST_RESCALE_CHK,
    ST_SUM,
    ST_SUM_WAIT,
    ST_SUM_SET,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic sym_bad;
    logic sym_end;
    logic idx_at_sym;
    logic idx_at_last;
    logic pfx_ok;
    logic range_ok;
    logic range_zero;
    logic cnt_sat;
    logic need_rescale;
    logic pend_valid;
    logic out_free;
    logic emit_ready;
  } dp_status_t;

endpackage

// ===== design/are_ram.sv =====
`timescale 1ns / 1ps

module are_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/are_ctrl.sv =====
`timescale 1ns / 1ps

module are_ctrl
  import are_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output cmd_t       cmd
);

  state_t             state, state_next;
  logic [INNER_W-1:0] inner, inner_next;
  logic [3:0]         outer, outer_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR_INIT;
      inner <= '0;
      outer <= '0;
    end else begin
      state <= state_next;
      inner <= inner_next;
      outer <= outer_next;
    end
  end

  always_comb begin
    state_next = state;
    inner_next = inner;
    outer_next = outer;
    cmd.op     = OP_NONE;
    in_stall   = 1'b1;
    case (state)
      ST_CLR_INIT: begin
        cmd.op     = OP_MODEL_RST;
        state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd.op = OP_CLR;
        if (status.idx_at_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op     = OP_START;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = status.sym_bad ? ST_IDLE : ST_WALK;
      end
      ST_WALK: begin
        cmd.op = OP_WALK;
        if (status.idx_at_sym) state_next = ST_WALK_WAIT;
      end
      ST_WALK_WAIT: state_next = ST_MUL_A;
      ST_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.op     = OP_MUL_B;
        state_next = ST_DIV_A_LOAD;
      end
      ST_DIV_A_LOAD: begin
        cmd.op     = OP_DIV_LOAD_A;
        inner_next = '0;
        state_next = ST_DIV_A;
      end
      ST_DIV_A: begin
        cmd.op     = OP_DIV_STEP;
        inner_next = inner + 1'b1;
        if (inner == INNER_W'(PROD_W - 1)) state_next = ST_DIV_B_LOAD;
      end
      ST_DIV_B_LOAD: begin
        cmd.op     = OP_DIV_LOAD_B;
        inner_next = '0;
        state_next = ST_DIV_B;
      end
      ST_DIV_B: begin
        cmd.op     = OP_DIV_STEP;
        inner_next = inner + 1'b1;
        if (inner == INNER_W'(PROD_W - 1)) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.op     = OP_APPLY;
        inner_next = '0;
        outer_next = '0;
        state_next = ST_PFX;
      end
      ST_PFX: begin
        if (inner == INNER_W'(PFX_ITERS) || !status.pfx_ok) begin
          state_next = ST_RANGE;
        end else if (status.emit_ready) begin
          cmd.op     = OP_EMIT_SHIFT;
          inner_next = inner + 1'b1;
        end
      end
      ST_RANGE: begin
        if (status.range_ok) begin
          state_next = ST_ADAPT;
        end else begin
          cmd.op     = OP_CUT;
          outer_next = outer + 1'b1;
          inner_next = '0;
          state_next = (outer == 4'(CUT_ITERS - 1)) ? ST_ADAPT : ST_PFX;
        end
      end
      ST_ADAPT: begin
        inner_next = '0;
        if (status.sym_end) begin
          state_next = ST_FLUSH;
        end else if (status.cnt_sat) begin
          state_next = ST_FINISH;
        end else begin
          cmd.op     = OP_INC;
          state_next = ST_RESCALE_CHK;
        end
      end
      ST_RESCALE_CHK: begin
        if (status.need_rescale) begin
          cmd.op     = OP_SHIFT;
          state_next = ST_SUM;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SUM: begin
        cmd.op = OP_SUM;
        if (status.idx_at_last) state_next = ST_SUM_WAIT;
      end
      ST_SUM_WAIT: state_next = ST_SUM_SET;
      ST_SUM_SET: begin
        cmd.op     = OP_SET_TOTAL;
        state_next = ST_FINISH;
      end
      ST_FLUSH: begin
        if (inner == INNER_W'(FLUSH_BYTES) || status.range_zero) begin
          state_next = ST_FINISH;
        end else if (status.emit_ready) begin
          cmd.op     = OP_EMIT_SHIFT;
          inner_next = inner + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!status.pend_valid || status.out_free) begin
          if (status.pend_valid) cmd.op = OP_FIN;
          state_next = status.sym_end ? ST_CLR_INIT : ST_IDLE;
        end
      end
      default: state_next = ST_CLR_INIT;
    endcase
  end

endmodule

// ===== design/are_dpath.sv =====
`timescale 1ns / 1ps

module are_dpath
  import are_pkg::*;
#(
  parameter int NUM_SYMBOLS = 257,
  parameter int COUNT_BITS  = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output dp_status_t       status,
  input  logic [SYM_W-1:0] symbol,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             end_of_stream
);

  localparam int ADDR_W = $clog2(NUM_SYMBOLS);

  function automatic logic [TOT_W-1:0] eff_of(input logic [31:0] c, input logic [4:0] sh);
    logic [31:0] v;
    v = c >> sh;
    return (v == 32'd0) ? TOT_W'(1) : v[TOT_W-1:0];
  endfunction

  // model state
  logic [4:0]        shift;
  logic [TOT_W-1:0]  total;
  logic [31:0]       low;
  logic [31:0]       range;

  // per-symbol working registers
  logic [SYM_W-1:0]      sym;
  logic [ADDR_W-1:0]     sym_idx;
  logic [ADDR_W-1:0]     idx;
  logic [TOT_W-1:0]      acc;
  logic [COUNT_BITS-1:0] cnt_s;
  logic                  rd_pend;
  logic                  rd_tag;
  logic [PROD_W-1:0]     prod_a, prod_b;
  logic [PROD_W-1:0]     dq;
  logic [TOT_W-1:0]      rem;
  logic [31:0]           qa;

  // output side
  logic [7:0]       pend_byte;
  logic             pend_valid;
  logic [RES_W-1:0] res_n;

  // count store
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;

  are_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_SYMBOLS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  logic [COUNT_BITS-1:0] cnt_inc;
  logic [31:0]           cnt_inc32;
  logic [31:0]           mask;
  logic                  step_up;
  logic [TOT_W-1:0]      mul_src;
  logic [TOT_W:0]        div_t;
  logic                  div_ge;
  logic [31:0]           hi;
  logic [31:0]           iv_end;
  logic [31:0]           mid;
  logic [31:0]           cut_a;
  logic [31:0]           cut_b;
  logic                  emit_go;

  always_comb begin
    cnt_inc   = cnt_s + 1'b1;
    cnt_inc32 = 32'(cnt_inc);
    mask      = 32'd1 << shift;
    step_up   = (cnt_inc32 > mask) && ((cnt_inc32 & (mask - 32'd1)) == 32'd0);
    mul_src   = (cmd.op == OP_MUL_B) ? eff_of(32'(cnt_s), shift) : acc;
    div_t     = {rem, dq[PROD_W-1]};
    div_ge    = div_t >= {1'b0, total};
    hi        = low + range - 32'd1;
    iv_end    = low + range;
    mid       = (iv_end - 32'd1) & TOP_MASK;
    cut_a     = mid - low;
    cut_b     = iv_end - mid;
    emit_go   = (cmd.op == OP_EMIT_SHIFT) && (res_n != RES_W'(MAX_RESULTS));

    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    if (cmd.op == OP_CLR) begin
      ram_we = 1'b1;
    end else if (cmd.op == OP_INC) begin
      ram_we    = 1'b1;
      ram_waddr = sym_idx;
      ram_wdata = cnt_inc;
    end
  end

  always_comb begin
    status.sym_bad      = 32'(sym) >= NUM_SYMBOLS;
    status.sym_end      = 32'(sym) == NUM_SYMBOLS - 1;
    status.idx_at_sym   = idx == sym_idx;
    status.idx_at_last  = idx == ADDR_W'(NUM_SYMBOLS - 1);
    status.pfx_ok       = (low[31:24] == hi[31:24]) && (range[23:0] != LOW_ZERO);
    status.range_ok     = range >= RANGE_MIN;
    status.range_zero   = range == 32'd0;
    status.cnt_sat      = cnt_s == {COUNT_BITS{1'b1}};
    status.need_rescale = (total > TOTAL_LIMIT) && (shift != SHIFT_MAX);
    status.pend_valid   = pend_valid;
    status.out_free     = !out_valid || !out_stall;
    status.emit_ready   = !pend_valid || !out_valid || !out_stall;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shift      <= '0;
      total      <= TOT_W'(NUM_SYMBOLS);
      low        <= '0;
      range      <= RANGE_FULL;
      idx        <= '0;
      rd_pend    <= 1'b0;
      pend_valid <= 1'b0;
      res_n      <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_pend <= (cmd.op == OP_WALK) || (cmd.op == OP_SUM);
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (cmd.op)
        OP_MODEL_RST: begin
          shift <= '0;
          total <= TOT_W'(NUM_SYMBOLS);
          low   <= '0;
          range <= RANGE_FULL;
          idx   <= '0;
        end
        OP_CLR, OP_WALK, OP_SUM: idx <= idx + 1'b1;
        OP_START: begin
          idx   <= '0;
          res_n <= '0;
        end
        OP_APPLY: begin
          low   <= low + qa;
          range <= dq[31:0];
        end
        OP_EMIT_SHIFT: begin
          low   <= low << 8;
          range <= range << 8;
          if (emit_go) begin
            res_n      <= res_n + 1'b1;
            pend_valid <= 1'b1;
            if (pend_valid) out_valid <= 1'b1;
          end
        end
        OP_CUT: begin
          if (cut_a >= cut_b) begin
            range <= cut_a;
          end else begin
            range <= range - cut_a;
            low   <= mid;
          end
        end
        OP_INC: begin
          if (step_up) total <= total + 1'b1;
        end
        OP_SHIFT: begin
          shift <= shift + 1'b1;
          idx   <= '0;
        end
        OP_SET_TOTAL: total <= acc;
        OP_FIN: begin
          pend_valid <= 1'b0;
          out_valid  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      if (rd_tag) begin
        cnt_s <= ram_rdata;
      end else begin
        acc <= acc + eff_of(32'(ram_rdata), shift);
      end
    end
    case (cmd.op)
      OP_START: begin
        sym     <= symbol;
        sym_idx <= ADDR_W'(symbol);
        acc     <= '0;
      end
      OP_WALK: rd_tag <= (idx == sym_idx);
      OP_SUM:  rd_tag <= 1'b0;
      OP_SHIFT: acc   <= '0;
      OP_MUL_A: prod_a <= PROD_W'(mul_src) * PROD_W'(range);
      OP_MUL_B: prod_b <= PROD_W'(mul_src) * PROD_W'(range);
      OP_DIV_LOAD_A: begin
        dq  <= prod_a;
        rem <= '0;
      end
      OP_DIV_LOAD_B: begin
        qa  <= dq[31:0];
        dq  <= prod_b;
        rem <= '0;
      end
      OP_DIV_STEP: begin
        rem <= div_ge ? TOT_W'(div_t - {1'b0, total}) : div_t[TOT_W-1:0];
        dq  <= {dq[PROD_W-2:0], div_ge};
      end
      OP_EMIT_SHIFT: begin
        if (emit_go) begin
          pend_byte <= low[31:24];
          if (pend_valid) begin
            out_byte      <= pend_byte;
            last_of_run   <= 1'b0;
            end_of_stream <= 1'b0;
          end
        end
      end
      OP_FIN: begin
        out_byte      <= pend_byte;
        last_of_run   <= 1'b1;
        end_of_stream <= status.sym_end;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/adaptive_range_encoder.sv =====
// Per symbol s: a walk of the count RAM up to entry s, two bit-serial 49-bit divisions, the
//   emitted bytes, the interval cuts and any byte-channel stall set the time taken; a new
//   symbol is accepted only once the last one is done.
// A count step that pushes the total past 0xffff adds a re-summing pass over the count RAM.
// Output: bytes follow the divisions, via a pending register into the output register.
// Reset: synchronous, active high; then a clearing pass of the count RAM with in_stall high.
//   The end symbol repeats that pass after its last beat.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adaptive_range_encoder
  import are_pkg::*;
#(
  parameter int NUM_SYMBOLS = 257,
  parameter int COUNT_BITS  = 32
) (
  input  logic             clk,
  input  logic             rst,
  // symbol channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [SYM_W-1:0] symbol,
  // byte channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             end_of_stream
);

  // Controller sequences walk, multiply, divide, renormalise, adapt and flush;
  // the datapath holds the model, the count RAM and the output beat registers.
  cmd_t       cmd;
  dp_status_t status;

  are_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  are_dpath #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .symbol        (symbol),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .end_of_stream (end_of_stream)
  );

  // end of stream only ever rides on the closing beat of a symbol
  `AR_ASSERT(a_eos_is_last, out_valid && end_of_stream |-> last_of_run)
  // one symbol at a time: busy right after an accepted beat
  `AR_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall)
  // clearing pass follows reset
  `AR_ASSERT_ALWAYS(a_clear_after_reset, rst |=> in_stall)

endmodule

// ===== tb/tb_adaptive_range_encoder.sv =====
`timescale 1ns / 1ps

module tb_adaptive_range_encoder;
  import are_pkg::*;

  localparam int NSYM     = 257;
  localparam int END_SYM  = NSYM - 1;
  localparam int BAD_SYM  = 511;
  localparam int N_RANDOM = 285;
  localparam int N_DIR    = 26;

  // stimulus row kinds: checked by predictor only, or also against a typed-in value
  typedef enum logic [1:0] {ROW_PRED, ROW_FIXED} row_kind_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
    logic       eos;
  } enc_beat_t;

  // fixed[k] is the k-th typed-in beat (ROW_FIXED only)
  typedef struct packed {
    row_kind_t       kind;
    logic [8:0]      sym;
    logic [2:0]      n_fixed;
    logic [3:0][7:0] fixed;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    // fresh model, end marker alone: one prefix byte, then three flush bytes
    '{ROW_FIXED, 9'd256, 3'd4, {8'h00, 8'hff, 8'h00, 8'hff}},
    // after the end marker the model is fresh again: symbol 0 gives one zero byte
    '{ROW_FIXED, 9'd0,   3'd1, 32'h0000_0000},
    // out-of-range symbols: no beats
    '{ROW_FIXED, 9'(BAD_SYM), 3'd0, 32'h0},
    '{ROW_FIXED, 9'd257, 3'd0, 32'h0},
    '{ROW_PRED,  9'd255, 3'd0, 32'h0},
    '{ROW_PRED,  9'd0,   3'd0, 32'h0},
    '{ROW_PRED,  9'd0,   3'd0, 32'h0},
    '{ROW_PRED,  9'd0,   3'd0, 32'h0},
    '{ROW_PRED,  9'd0,   3'd0, 32'h0},
    '{ROW_PRED,  9'd1,   3'd0, 32'h0},
    '{ROW_PRED,  9'd128, 3'd0, 32'h0},
    '{ROW_PRED,  9'd255, 3'd0, 32'h0},
    '{ROW_PRED,  9'd256, 3'd0, 32'h0},
    '{ROW_FIXED, 9'd0,   3'd1, 32'h0000_0000},
    '{ROW_PRED,  9'd3,   3'd0, 32'h0},
    '{ROW_PRED,  9'd3,   3'd0, 32'h0},
    '{ROW_PRED,  9'd3,   3'd0, 32'h0},
    '{ROW_PRED,  9'd200, 3'd0, 32'h0},
    '{ROW_PRED,  9'd17,  3'd0, 32'h0},
    '{ROW_PRED,  9'd17,  3'd0, 32'h0},
    '{ROW_PRED,  9'd256, 3'd0, 32'h0},
    '{ROW_FIXED, 9'd256, 3'd4, {8'h00, 8'hff, 8'h00, 8'hff}},
    '{ROW_FIXED, 9'd510, 3'd0, 32'h0},
    '{ROW_PRED,  9'd42,  3'd0, 32'h0},
    '{ROW_PRED,  9'd7,   3'd0, 32'h0},
    '{ROW_PRED,  9'd7,   3'd0, 32'h0}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [SYM_W-1:0] symbol = '0;
  logic             out_valid;
  logic             out_stall = 1'b1;
  logic [7:0]       out_byte;
  logic             last_of_run;
  logic             end_of_stream;

  adaptive_range_encoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .symbol(symbol),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .last_of_run(last_of_run), .end_of_stream(end_of_stream)
  );

  always #10 clk = ~clk;

  // --- predictor state: own copy of the adaptive model ---
  logic [31:0] freq [NSYM];
  logic [4:0]  shamt;
  logic [31:0] freq_total;
  logic [31:0] lo, rng;

  enc_beat_t pending_bytes [$];   // bytes still owed by the encoder
  enc_beat_t sym_bytes [$];       // bytes for the symbol being predicted

  enc_beat_t exp_beat;
  enc_beat_t got_beat;

  int n_err = 0;
  int n_bytes = 0;
  int n_syms = 0;
  int n_ends = 0;

  function automatic void mismatch(input string what, input enc_beat_t e, input enc_beat_t a);
    n_err++;
    if (n_err <= 10) begin
      $display("mismatch (%s) at %0t: expected byte %02h last %0b eos %0b, got byte %02h last %0b eos %0b",
               what, $time, e.byte_val, e.last, e.eos, a.byte_val, a.last, a.eos);
    end
  endfunction

  function automatic logic [31:0] p_eff(input int s);
    logic [31:0] c;
    c = freq[s] >> shamt;
    return (c == 32'd0) ? 32'd1 : c;
  endfunction

  function automatic logic [31:0] p_sum();
    logic [31:0] t;
    t = '0;
    for (int i = 0; i < NSYM; i++) t = t + p_eff(i);
    return t;
  endfunction

  function automatic void p_reset();
    for (int i = 0; i < NSYM; i++) freq[i] = '0;
    shamt      = '0;
    freq_total = 32'(NSYM);
    lo         = '0;
    rng        = 32'hffff_ffff;
  endfunction

  function automatic void p_emit(input logic [7:0] b);
    enc_beat_t e;
    e.byte_val = b;
    e.last     = 1'b0;
    e.eos      = 1'b0;
    if (sym_bytes.size() < MAX_RESULTS) sym_bytes.push_back(e);
  endfunction

  function automatic void p_prefix();
    logic [31:0] hi;
    for (int k = 0; k < 8; k++) begin
      hi = lo + rng - 32'd1;
      if (lo[31:24] != hi[31:24] || rng[23:0] == 24'd0) break;
      p_emit(lo[31:24]);
      lo  = lo << 8;
      rng = rng << 8;
    end
  endfunction

  function automatic void p_cut();
    logic [31:0] iv_end;
    logic [31:0] mid;
    iv_end = lo + rng;
    mid    = (iv_end - 32'd1) & 32'hff00_0000;
    if (mid - lo >= iv_end - mid) begin
      rng = mid - lo;
    end else begin
      rng = rng - (mid - lo);
      lo  = mid;
    end
  endfunction

  function automatic void p_adapt(input int s);
    logic [31:0] msk;
    if (freq[s] == 32'hffff_ffff) return;
    freq[s] = freq[s] + 32'd1;
    msk = 32'd1 << shamt;
    if (freq[s] > msk && (freq[s] & (msk - 32'd1)) == 32'd0) begin
      freq_total = freq_total + 32'd1;
      if (freq_total > 32'h0000_ffff && shamt < 5'd31) begin
        shamt      = shamt + 5'd1;
        freq_total = p_sum();
      end
    end
  endfunction

  function automatic void p_encode(input int s);
    logic [31:0] start;
    logic [63:0] r64;
    start = '0;
    for (int i = 0; i < s; i++) start = start + p_eff(i);
    r64 = {32'd0, rng};
    lo  = lo + 32'((64'(start) * r64) / 64'(freq_total));
    rng = 32'((64'(p_eff(s)) * r64) / 64'(freq_total));
    for (int k = 0; k < 16; k++) begin
      p_prefix();
      if (rng >= 32'h0000_ffff) break;
      p_cut();
    end
    p_adapt(s);
  endfunction

  // fills sym_bytes with the beats one accepted symbol causes
  function automatic void predict(input logic [8:0] s_in);
    int        s;
    logic      is_end;
    enc_beat_t b;
    sym_bytes.delete();
    if (s_in >= 9'(NSYM)) return;
    s      = int'(s_in);
    is_end = (s == END_SYM);
    p_encode(s);
    if (is_end) begin
      for (int k = 0; k < 4 && rng != 32'd0; k++) begin
        p_emit(lo[31:24]);
        lo  = lo << 8;
        rng = rng << 8;
      end
      p_reset();
    end
    if (sym_bytes.size() > 0) begin
      b      = sym_bytes.pop_back();
      b.last = 1'b1;
      if (is_end) b.eos = 1'b1;
      sym_bytes.push_back(b);
    end
  endfunction

  function automatic void queue_predicted();
    foreach (sym_bytes[k]) pending_bytes.push_back(sym_bytes[k]);
  endfunction

  // typed-in beats drive the check; the predictor must agree with them as well
  function automatic void queue_fixed(input stim_row_t row);
    enc_beat_t b;
    enc_beat_t none;
    none = '0;
    if (sym_bytes.size() != int'(row.n_fixed)) mismatch("row length", none, none);
    for (int k = 0; k < int'(row.n_fixed); k++) begin
      b.byte_val = row.fixed[k];
      b.last     = (k == int'(row.n_fixed) - 1);
      b.eos      = b.last && (row.sym == 9'(END_SYM));
      if (k < sym_bytes.size() && sym_bytes[k] != b) mismatch("table row", b, sym_bytes[k]);
      pending_bytes.push_back(b);
    end
  endfunction

  // holds the beat until accepted; returns at the accepting edge
  task automatic send(input logic [8:0] s);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol   <= s;
    do @(posedge clk); while (in_stall);
    n_syms++;
    if (s == 9'(END_SYM)) n_ends++;
    predict(s);
  endtask

  // output side
  initial begin
    int og;
    while (rst) @(posedge clk);
    forever begin
      og = $urandom_range(0, 9);
      if (og > 0) begin
        out_stall <= 1'b1;
        repeat (og) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_bytes++;
      got_beat = {out_byte, last_of_run, end_of_stream};
      if (pending_bytes.size() == 0) begin
        mismatch("unexpected beat", '0, got_beat);
      end else begin
        exp_beat = pending_bytes.pop_front();
        if (exp_beat !== got_beat) mismatch("beat", exp_beat, got_beat);
      end
    end
  end

  initial begin
    int         pick;
    logic [8:0] s;
    p_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIR; r++) begin
      send(DIR_ROWS[r].sym);
      if (DIR_ROWS[r].kind == ROW_FIXED) queue_fixed(DIR_ROWS[r]);
      else queue_predicted();
    end

    for (int r = 0; r < N_RANDOM; r++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) s = 9'(END_SYM);
      else if (pick < 5) s = 9'(257 + $urandom_range(0, 254));
      else if (pick < 60) s = 9'($urandom_range(0, 7));
      else s = 9'($urandom_range(0, 255));
      send(s);
      queue_predicted();
    end
    in_valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("covered %0d symbols, %0d of them end markers, and %0d output beats,",
             n_syms, n_ends, n_bytes);
    $display("with typed-in and predicted rows, bad symbols and random gaps on both channels");
    if (n_err == 0 && pending_bytes.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("run timed out with %0d beats outstanding", pending_bytes.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
